@@ src/sha256_message_hash_unit_defines.svh @@
// Assertion macros shared by the hash unit and its round core.
// Both expect the clock aclk and the active-low synchronous reset aresetn.
`ifndef SHA256_MESSAGE_HASH_UNIT_DEFINES_SVH
`define SHA256_MESSAGE_HASH_UNIT_DEFINES_SVH

// The condition holding at an edge implies the property at the same edge.
`define SHAMH_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// The condition holding at an edge implies the property at the next edge.
`define SHAMH_ASSERT_NXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

@@ src/shamh_pkg.sv @@
package shamh_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int ROUNDS      = 64;

    localparam logic [2:0] WORD_BYTES  = 3'd4;
    localparam logic [7:0] PAD_MARK    = 8'h80;
    localparam logic [5:0] LEN_LIMIT   = 6'd56;
    localparam int         LEN_HI_WORD = 14;
    localparam int         LEN_LO_WORD = 15;

    typedef logic [BLOCK_WORDS-1:0][31:0] block_t;
    typedef logic [CHAIN_WORDS-1:0][31:0] chain_t;

    // Index 0 holds the first chaining word.
    localparam chain_t IV_WORDS = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    localparam logic [31:0] ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] data_word;
        logic [2:0]  byte_count;
        logic        last_word;
    } in_item_t;

    typedef struct packed {
        logic [63:0] digest_part;
        logic [1:0]  part_index;
        logic        last_part;
    } out_item_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ABSORB,
        S_PAD,
        S_LENGTH,
        S_START,
        S_WAIT,
        S_OUTPUT
    } hash_state_t;

endpackage

@@ src/sha256_message_hash_unit.sv @@
// SHA-256 hash unit for byte messages streamed as big-endian 32-bit words.
// Input channel s_*: one word per handshake, carrying up to four leading message
// bytes (byte_count, counts above four are taken as four) and a last_word flag.
// Output channel m_*: after the last word the unit gives the 256-bit digest as
// four 64-bit parts, most significant first, then clears itself for the next
// message.
// A word that does not complete a block is taken in an accept step and a merge
// step. A word that completes a 64-byte block then passes through a load of the
// round core, 64 rounds at one round per cycle, an add into the chaining words
// and a merge of any bytes left over. After the last word is merged the padding
// block is compressed, followed by a second block for the length when it does
// not fit, and the four parts then leave at one per cycle while m_ready is high.
// s_ready is high only while the unit is idle; it stays low from the accepted
// word until the word is merged or, for the last word, until the final part is
// taken. A stalled receiver simply holds the unit in its output phase with the
// current part steady. Reset loads the initial hash values and zeroes the fill
// count, not the buffer; the unit is ready in the first cycle after reset.
`include "sha256_message_hash_unit_defines.svh"

module sha256_message_hash_unit import shamh_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    hash_state_t state_reg;
    hash_state_t state_next;

    // Word being merged: the next byte to place sits in the top eight bits.
    logic [31:0] word_reg;
    logic [2:0]  remain_reg;
    logic        last_reg;

    logic [5:0]  fill_reg;
    logic [63:0] msg_bits_reg;
    logic        pad_reg;
    logic        need_len_reg;
    logic [1:0]  part_reg;
    block_t      block_reg;
    block_t      block_next;

    logic [2:0]  count_sat;
    logic [6:0]  space;
    logic [2:0]  take;
    logic [6:0]  fill_sum;
    logic [2:0]  remain_left;
    logic        final_taken;

    core_ctrl_t  core_ctrl;
    core_stat_t  core_stat;
    chain_t      chain;

    assign count_sat   = (s_data.byte_count > WORD_BYTES) ? WORD_BYTES : s_data.byte_count;
    assign space       = 7'd64 - {1'b0, fill_reg};
    assign take        = ({4'b0, remain_reg} < space) ? remain_reg : space[2:0];
    assign fill_sum    = {1'b0, fill_reg} + {4'b0, take};
    assign remain_left = remain_reg - take;
    assign final_taken = m_valid && m_ready && (part_reg == 2'd3);

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ABSORB;
                end
            end
            S_ABSORB: begin
                if (fill_sum[6]) begin
                    state_next = S_START;
                end else if (remain_left == '0) begin
                    state_next = last_reg ? S_PAD : S_IDLE;
                end
            end
            S_PAD, S_LENGTH: begin
                state_next = S_START;
            end
            S_START: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (core_stat.done) begin
                    if (!pad_reg) begin
                        state_next = S_ABSORB;
                    end else if (need_len_reg) begin
                        state_next = S_LENGTH;
                    end else begin
                        state_next = S_OUTPUT;
                    end
                end
            end
            S_OUTPUT: begin
                if (final_taken) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready        = (state_reg == S_IDLE);
        m_valid        = (state_reg == S_OUTPUT);
        core_ctrl.start = (state_reg == S_START);
        core_ctrl.init  = final_taken;
    end

    // Block buffer update: byte merge, padding and the length block.
    always_comb begin
        logic [5:0] pos;
        block_next = block_reg;
        pos        = '0;
        case (state_reg)
            S_ABSORB: begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < take) begin
                        pos = fill_reg + 6'(i);
                        block_next[pos[5:2]][{~pos[1:0], 3'b000} +: 8] =
                            word_reg[31 - 8*i -: 8];
                    end
                end
            end
            S_PAD: begin
                for (int p = 0; p < 64; p++) begin
                    pos = 6'(p);
                    if (pos == fill_reg) begin
                        block_next[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = PAD_MARK;
                    end else if (pos > fill_reg) begin
                        block_next[pos[5:2]][{~pos[1:0], 3'b000} +: 8] = '0;
                    end
                end
                if (fill_reg < LEN_LIMIT) begin
                    block_next[LEN_HI_WORD] = msg_bits_reg[63:32];
                    block_next[LEN_LO_WORD] = msg_bits_reg[31:0];
                end
            end
            S_LENGTH: begin
                block_next              = '0;
                block_next[LEN_HI_WORD] = msg_bits_reg[63:32];
                block_next[LEN_LO_WORD] = msg_bits_reg[31:0];
            end
            default: begin
                block_next = block_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            msg_bits_reg <= '0;
            pad_reg      <= 1'b0;
            need_len_reg <= 1'b0;
            part_reg     <= '0;
        end else begin
            state_reg <= state_next;
            case (state_reg)
                S_ABSORB: begin
                    fill_reg     <= fill_sum[5:0];
                    msg_bits_reg <= msg_bits_reg + 64'({take, 3'b000});
                end
                S_PAD: begin
                    pad_reg      <= 1'b1;
                    need_len_reg <= (fill_reg >= LEN_LIMIT);
                end
                S_LENGTH: begin
                    need_len_reg <= 1'b0;
                end
                S_OUTPUT: begin
                    if (m_ready) begin
                        part_reg <= part_reg + 2'd1;
                        if (part_reg == 2'd3) begin
                            fill_reg     <= '0;
                            msg_bits_reg <= '0;
                            pad_reg      <= 1'b0;
                            need_len_reg <= 1'b0;
                        end
                    end
                end
                default: begin
                    part_reg <= part_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        block_reg <= block_next;
        if (state_reg == S_IDLE && s_valid) begin
            word_reg   <= s_data.data_word;
            remain_reg <= count_sat;
            last_reg   <= s_data.last_word;
        end else if (state_reg == S_ABSORB) begin
            word_reg   <= word_reg << {take, 3'b000};
            remain_reg <= remain_left;
        end
    end

    shamh_round_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (core_ctrl),
        .block_in (block_reg),
        .stat     (core_stat),
        .chain    (chain)
    );

    // Digest parts: chaining words 2k and 2k+1, the first in the upper half.
    always_comb begin
        case (part_reg)
            2'd0:    m_data.digest_part = {chain[0], chain[1]};
            2'd1:    m_data.digest_part = {chain[2], chain[3]};
            2'd2:    m_data.digest_part = {chain[4], chain[5]};
            default: m_data.digest_part = {chain[6], chain[7]};
        endcase
        m_data.part_index = part_reg;
        m_data.last_part  = (part_reg == 2'd3);
    end

    `SHAMH_ASSERT_IMP(a_ready_excl, m_valid, !s_ready, "input taken while the digest is pending")
    `SHAMH_ASSERT_IMP(a_block_aligned, core_stat.done && !pad_reg, fill_reg == '0, "message block compressed before it was full")
    `SHAMH_ASSERT_IMP(a_core_free, state_reg == S_START, !core_stat.busy && !core_stat.done, "round core started while still working")
    `SHAMH_ASSERT_NXT(a_back_to_idle, final_taken, s_ready && (part_reg == '0) && (fill_reg == '0), "unit not cleared after the final part")

endmodule

@@ src/shamh_round_core.sv @@
`include "sha256_message_hash_unit_defines.svh"

module shamh_round_core import shamh_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  core_ctrl_t ctrl,
    input  block_t     block_in,
    output core_stat_t stat,
    output chain_t     chain
);

    chain_t      chain_reg;
    chain_t      work_reg;
    block_t      sched_reg;
    logic [5:0]  round_reg;
    logic        busy_reg;
    logic        fin_reg;

    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] w_new;
    logic [31:0] big0;
    logic [31:0] big1;
    logic [31:0] sml0;
    logic [31:0] sml1;
    logic [31:0] choose;
    logic [31:0] major;

    // Working words: index 0 is a, index 7 is h.
    always_comb begin
        big0   = {work_reg[0][1:0],   work_reg[0][31:2]}
               ^ {work_reg[0][12:0],  work_reg[0][31:13]}
               ^ {work_reg[0][21:0],  work_reg[0][31:22]};
        big1   = {work_reg[4][5:0],   work_reg[4][31:6]}
               ^ {work_reg[4][10:0],  work_reg[4][31:11]}
               ^ {work_reg[4][24:0],  work_reg[4][31:25]};
        choose = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        major  = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]);
        t1     = work_reg[7] + big1 + choose + ROUND_K[round_reg] + sched_reg[0];
        t2     = big0 + major;
        sml0   = {sched_reg[1][6:0],   sched_reg[1][31:7]}
               ^ {sched_reg[1][17:0],  sched_reg[1][31:18]}
               ^ (sched_reg[1] >> 3);
        sml1   = {sched_reg[14][16:0], sched_reg[14][31:17]}
               ^ {sched_reg[14][18:0], sched_reg[14][31:19]}
               ^ (sched_reg[14] >> 10);
        w_new  = sml1 + sched_reg[9] + sml0 + sched_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= IV_WORDS;
            round_reg <= '0;
            busy_reg  <= 1'b0;
            fin_reg   <= 1'b0;
        end else begin
            fin_reg <= busy_reg && (round_reg == 6'(ROUNDS - 1));
            if (ctrl.init) begin
                chain_reg <= IV_WORDS;
            end else if (fin_reg) begin
                for (int i = 0; i < CHAIN_WORDS; i++) begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
            if (ctrl.start) begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end else if (busy_reg) begin
                round_reg <= round_reg + 6'd1;
                if (round_reg == 6'(ROUNDS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            work_reg  <= chain_reg;
            sched_reg <= block_in;
        end else if (busy_reg) begin
            work_reg[7] <= work_reg[6];
            work_reg[6] <= work_reg[5];
            work_reg[5] <= work_reg[4];
            work_reg[4] <= work_reg[3] + t1;
            work_reg[3] <= work_reg[2];
            work_reg[2] <= work_reg[1];
            work_reg[1] <= work_reg[0];
            work_reg[0] <= t1 + t2;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[BLOCK_WORDS-1] <= w_new;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = fin_reg;
    assign chain     = chain_reg;

    `SHAMH_ASSERT_NXT(a_start_loads, ctrl.start, busy_reg && (round_reg == '0), "start did not begin round zero")
    `SHAMH_ASSERT_NXT(a_fin_follows, busy_reg && (round_reg == 6'(ROUNDS - 1)), fin_reg && !busy_reg, "final add did not follow the last round")
    `SHAMH_ASSERT_IMP(a_fin_alone, fin_reg, !busy_reg && !ctrl.start, "final add overlaps a compression")

endmodule

@@ tb/tb_sha256_message_hash_unit.sv @@
module tb_sha256_message_hash_unit;
    import shamh_pkg::*;

    // The random part stops once this many words that carry bytes or end a
    // message have been accepted after the directed table.
    localparam int unsigned RANDOM_WORDS = 190;
    // Cycles waited after the last expected part has been taken, before the verdict.
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // One row of the directed table. Where typed is set, the digest column
    // holds the known answer; otherwise the answer comes from the hash model.
    typedef struct {
        in_item_t     word;
        bit           typed;
        logic [255:0] digest;
    } stim_row_t;

    localparam logic [255:0] EMPTY_DIGEST =
        256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
    localparam logic [255:0] ABC_DIGEST =
        256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

    // Software copy of the hash state, updated on every accepted word.
    logic [31:0] sha_chain [CHAIN_WORDS];
    logic [31:0] sha_block [BLOCK_WORDS];
    int unsigned sha_fill;
    logic [63:0] sha_bits;

    // Digest parts still owed by the unit, oldest first.
    out_item_t   expected_parts [$];
    stim_row_t   directed_rows [$];

    int unsigned wrong_fields = 0;
    int unsigned cycle_count = 0;
    int unsigned words_sent = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    sha256_message_hash_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // A generous watchdog: the slowest legal run is far below this.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("sha256_message_hash_unit: mismatch");
            $finish;
        end
    end

    function automatic logic [31:0] ror32(logic [31:0] v, int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic void sha_restart();
        for (int i = 0; i < CHAIN_WORDS; i++) begin
            sha_chain[i] = IV_WORDS[i];
        end
        for (int i = 0; i < BLOCK_WORDS; i++) begin
            sha_block[i] = '0;
        end
        sha_fill = 0;
        sha_bits = '0;
    endfunction

    // One full block through the 64-round schedule, folded into the chain.
    function automatic void sha_compress();
        logic [31:0] sched [ROUNDS];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
        for (int t = 0; t < BLOCK_WORDS; t++) begin
            sched[t] = sha_block[t];
        end
        for (int t = BLOCK_WORDS; t < ROUNDS; t++) begin
            sched[t] = sched[t-16] + sched[t-7]
                     + (ror32(sched[t-15], 7) ^ ror32(sched[t-15], 18) ^ (sched[t-15] >> 3))
                     + (ror32(sched[t-2], 17) ^ ror32(sched[t-2], 19) ^ (sched[t-2] >> 10));
        end
        a = sha_chain[0]; b = sha_chain[1]; c = sha_chain[2]; d = sha_chain[3];
        e = sha_chain[4]; f = sha_chain[5]; g = sha_chain[6]; h = sha_chain[7];
        for (int r = 0; r < ROUNDS; r++) begin
            t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_K[r] + sched[r];
            t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        sha_chain[0] += a; sha_chain[1] += b; sha_chain[2] += c; sha_chain[3] += d;
        sha_chain[4] += e; sha_chain[5] += f; sha_chain[6] += g; sha_chain[7] += h;
    endfunction

    function automatic void sha_absorb_byte(logic [7:0] b);
        int unsigned slot;
        int unsigned sh;
        slot = sha_fill >> 2;
        sh = 24 - 8 * (sha_fill % 4);
        if (sha_fill % 4 == 0) begin
            sha_block[slot] = 32'(b) << sh;
        end else begin
            sha_block[slot] |= 32'(b) << sh;
        end
        sha_fill = (sha_fill + 1) % 64;
        if (sha_fill == 0) begin
            sha_compress();
        end
    endfunction

    // Takes one accepted word. Returns 1 with the digest when the word ends
    // a message, after which the model is back in its reset state.
    function automatic bit sha_hash_word(in_item_t w, output logic [255:0] dg);
        int unsigned count;
        logic [63:0] len;
        dg = '0;
        count = (w.byte_count > WORD_BYTES) ? 4 : int'(w.byte_count);
        for (int i = 0; i < count; i++) begin
            sha_absorb_byte(w.data_word[31 - 8 * i -: 8]);
            sha_bits += 64'd8;
        end
        if (!w.last_word) begin
            return 1'b0;
        end
        len = sha_bits;
        sha_absorb_byte(PAD_MARK);
        while (sha_fill != LEN_LIMIT) begin
            sha_absorb_byte(8'h00);
        end
        for (int i = 0; i < 8; i++) begin
            sha_absorb_byte(len[63 - 8 * i -: 8]);
        end
        for (int k = 0; k < CHAIN_WORDS; k++) begin
            dg[255 - 32 * k -: 32] = sha_chain[k];
        end
        sha_restart();
        return 1'b1;
    endfunction

    // Offers one word, waits for the handshake, then books the digest parts
    // that the word brings about. The sender may idle before the word, but
    // once valid is raised it stays up with the payload held until taken.
    task automatic send_row(stim_row_t row);
        logic [255:0] dg;
        out_item_t    part;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= row.word;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        if (row.word.byte_count != 3'd0 || row.word.last_word) begin
            words_sent++;
        end
        if (sha_hash_word(row.word, dg)) begin
            if (row.typed) begin
                dg = row.digest;
            end
            for (int k = 0; k < 4; k++) begin
                part.digest_part = dg[255 - 64 * k -: 64];
                part.part_index  = 2'(k);
                part.last_part   = (k == 3);
                expected_parts.insert(expected_parts.size(), part);
            end
        end
    endtask

    // A message as a run of words. A well-formed message packs four bytes per
    // word with any short word at the end; a noisy one uses random byte
    // counts, saturating counts and zero-count words throughout.
    task automatic send_message(int unsigned nbytes, bit noisy, int unsigned noisy_words);
        stim_row_t   row;
        int unsigned left;
        row.typed  = 1'b0;
        row.digest = '0;
        if (noisy) begin
            for (int unsigned i = 0; i < noisy_words; i++) begin
                row.word.data_word  = $urandom;
                row.word.byte_count = 3'($urandom_range(7));
                row.word.last_word  = (i == noisy_words - 1);
                send_row(row);
            end
        end else begin
            left = nbytes;
            do begin
                row.word.data_word  = $urandom;
                row.word.byte_count = (left > 4) ? WORD_BYTES : 3'(left);
                left -= int'(row.word.byte_count);
                row.word.last_word  = (left == 0);
                send_row(row);
            end while (left != 0);
        end
    endtask

    function automatic void note_wrong(string field, logic [63:0] want, logic [63:0] got);
        wrong_fields++;
        if (wrong_fields <= 10) begin
            $display("%s wrong: expected %h, got %h", field, want, got);
        end
    endfunction

    // Appends one row to the end of the directed table.
    function automatic void add_row(stim_row_t r);
        directed_rows.insert(directed_rows.size(), r);
    endfunction

    // Result side: every part taken is held against the oldest expectation,
    // and the receiver's readiness is redrawn each cycle.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_parts.size() == 0) begin
                note_wrong("unexpected part", 64'd0, m_data.digest_part);
            end else begin
                want = expected_parts.pop_front();
                if (m_data.digest_part !== want.digest_part) begin
                    note_wrong("digest_part", want.digest_part, m_data.digest_part);
                end
                if (m_data.part_index !== want.part_index) begin
                    note_wrong("part_index", 64'(want.part_index), 64'(m_data.part_index));
                end
                if (m_data.last_part !== want.last_part) begin
                    note_wrong("last_part", 64'(want.last_part), 64'(m_data.last_part));
                end
            end
        end
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin
        stim_row_t   row;
        int unsigned pick;
        int unsigned nbytes;
        int unsigned phase;
        int unsigned boundary [12];

        boundary = '{55, 56, 57, 59, 60, 63, 64, 65, 119, 120, 127, 128};
        sha_restart();

        // Directed table. The empty message is given twice, once with junk in
        // the unused data bits; the three-byte message is the classic "abc".
        row.typed = 1'b1;
        row.digest = EMPTY_DIGEST;
        row.word = '{data_word: 32'h0000_0000, byte_count: 3'd0, last_word: 1'b1};
        add_row(row);
        row.digest = ABC_DIGEST;
        row.word = '{data_word: 32'h6162_63ff, byte_count: 3'd3, last_word: 1'b1};
        add_row(row);
        row.typed = 1'b0;
        row.digest = '0;
        // Byte counts of five to seven are taken as four.
        row.word = '{data_word: 32'hffff_ffff, byte_count: 3'd7, last_word: 1'b0};
        add_row(row);
        row.word = '{data_word: 32'h0000_0000, byte_count: 3'd5, last_word: 1'b0};
        add_row(row);
        row.word = '{data_word: 32'ha5a5_a5a5, byte_count: 3'd6, last_word: 1'b1};
        add_row(row);
        // Short words before the end, and a word with no bytes that is not last.
        row.word = '{data_word: 32'h1234_5678, byte_count: 3'd1, last_word: 1'b0};
        add_row(row);
        row.word = '{data_word: 32'hdead_beef, byte_count: 3'd0, last_word: 1'b0};
        add_row(row);
        row.word = '{data_word: 32'h9abc_def0, byte_count: 3'd2, last_word: 1'b0};
        add_row(row);
        row.word = '{data_word: 32'hfedc_ba98, byte_count: 3'd4, last_word: 1'b1};
        add_row(row);
        // A 56-byte message: the length no longer fits, so padding needs a second
        // block for the length.
        for (int i = 0; i < 14; i++) begin
            row.word.data_word  = (i % 2 == 0) ? 32'hffff_ffff : 32'h0000_0000;
            row.word.byte_count = WORD_BYTES;
            row.word.last_word  = (i == 13);
            add_row(row);
        end
        row.typed = 1'b1;
        row.digest = EMPTY_DIGEST;
        row.word = '{data_word: 32'hffff_ffff, byte_count: 3'd0, last_word: 1'b1};
        add_row(row);

        // Synchronous reset at the start, applied once only.
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_row(directed_rows[i]);
        end

        // Random messages, spread over four idling phases by words sent:
        // none, sender mostly idle, receiver mostly stalled, both lightly.
        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            phase = (words_sent * 4) / RANDOM_WORDS;
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 82; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 82; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            pick = $urandom_range(99);
            if (pick < 20) begin
                send_message(0, 1'b1, $urandom_range(1, 12));
            end else begin
                if (pick < 55) begin
                    nbytes = $urandom_range(0, 20);
                end else if (pick < 80) begin
                    nbytes = boundary[$urandom_range(11)];
                end else begin
                    nbytes = $urandom_range(0, 260);
                end
                send_message(nbytes, 1'b0, 0);
            end
        end
        s_valid <= 1'b0;

        while (expected_parts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (wrong_fields == 0 && expected_parts.size() == 0) begin
            $display("sha256_message_hash_unit: match");
        end else begin
            $display("sha256_message_hash_unit: mismatch");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/shamh_pkg.sv
src/shamh_round_core.sv
src/sha256_message_hash_unit.sv
tb/tb_sha256_message_hash_unit.sv
